>>> src/huffman_tree_codec_core_macros.svh
// Assertion macros shared by the Huffman tree codec RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef HUFFMAN_TREE_CODEC_CORE_MACROS_SVH
`define HUFFMAN_TREE_CODEC_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/htc_pkg.sv
// Package for the Huffman tree codec: beat structs, codes and the default weights.
// No dependencies; used by huffman_tree_codec_core.
package htc_pkg;

	localparam int MAX_SYMBOLS_DEF = 32;
	localparam int WEIGHT_BITS_DEF = 16;
	localparam int RESET_COUNT     = 27;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_BUILD  = 2'd1;
	localparam logic [1:0] ACT_ENCODE = 2'd2;
	localparam logic [1:0] ACT_DECODE = 2'd3;

	localparam logic [1:0] KIND_BUILD  = 2'd0;
	localparam logic [1:0] KIND_CODE   = 2'd1;
	localparam logic [1:0] KIND_SYMBOL = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_NO_TREE = 2'd1;
	localparam logic [1:0] ERR_RANGE   = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [4:0]  symbol;
		logic [15:0] weight;
		logic        code_bit;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       out_bit;
		logic [4:0] out_symbol;
		logic       last;
		logic [1:0] error_code;
	} out_item_t;

	// Default letter frequencies: space, then A to Z.
	function automatic logic [7:0] dflt_weight(input logic [6:0] idx);
		logic [7:0] w;
		case (idx)
			7'd0:  w = 8'd186;
			7'd1:  w = 8'd64;
			7'd2:  w = 8'd13;
			7'd3:  w = 8'd22;
			7'd4:  w = 8'd32;
			7'd5:  w = 8'd103;
			7'd6:  w = 8'd21;
			7'd7:  w = 8'd15;
			7'd8:  w = 8'd47;
			7'd9:  w = 8'd57;
			7'd10: w = 8'd1;
			7'd11: w = 8'd5;
			7'd12: w = 8'd32;
			7'd13: w = 8'd20;
			7'd14: w = 8'd57;
			7'd15: w = 8'd63;
			7'd16: w = 8'd15;
			7'd17: w = 8'd1;
			7'd18: w = 8'd48;
			7'd19: w = 8'd51;
			7'd20: w = 8'd80;
			7'd21: w = 8'd23;
			7'd22: w = 8'd8;
			7'd23: w = 8'd18;
			7'd24: w = 8'd1;
			7'd25: w = 8'd16;
			7'd26: w = 8'd1;
			default: w = 8'd0;
		endcase
		return w;
	endfunction

endpackage

>>> src/huffman_tree_codec_core.sv
// Huffman tree codec. Load writes one leaf weight. Build with n leaves runs S_BINIT,
// then per merge a scan of all earlier nodes through the node memory read port and the
// S_MRGA and S_MRGB steps. Encode follows parent links (S_EREQ, S_EWAIT per link), then
// emits one bit per S_EEMIT. Decode runs S_DREQ, S_DWAIT. Errors are reported from idle.
// One item at a time; results are strobed for one cycle, never stalled.
// Reset clears control, puts default weights on the leaves and leaves no tree built.
`include "huffman_tree_codec_core_macros.svh"

module huffman_tree_codec_core #(
	parameter int MAX_SYMBOLS = htc_pkg::MAX_SYMBOLS_DEF,
	parameter int WEIGHT_BITS = htc_pkg::WEIGHT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  htc_pkg::in_item_t in_item,
	output logic              result_valid,
	output htc_pkg::out_item_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import htc_pkg::*;

	// Node table geometry. Leaves and internal nodes share one index space.
	localparam int NODES = 2 * MAX_SYMBOLS - 1;
	localparam int NW    = $clog2(NODES);
	localparam int LW    = $clog2(MAX_SYMBOLS);
	localparam int CW    = $clog2(MAX_SYMBOLS + 1);
	localparam int NWW   = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
	localparam int RST_N = (MAX_SYMBOLS < RESET_COUNT) ? MAX_SYMBOLS : RESET_COUNT;
	localparam logic [NWW-1:0] WMASK = {{(NWW - WEIGHT_BITS){1'b0}}, {WEIGHT_BITS{1'b1}}};

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_BINIT = 10'b0000000010,
		S_SCAN  = 10'b0000000100,
		S_MRGA  = 10'b0000001000,
		S_MRGB  = 10'b0000010000,
		S_EREQ  = 10'b0000100000,
		S_EWAIT = 10'b0001000000,
		S_EEMIT = 10'b0010000000,
		S_DREQ  = 10'b0100000000,
		S_DWAIT = 10'b1000000000
	} state_t;

	state_t state_q;

	// The two node memories. A node entry holds its children on top of its weight;
	// parent entries carry the branch bit on top.
	logic [2*NW+NWW-1:0] nmem [NODES];
	logic [NW:0]         pmem [NODES];
	logic [2*NW+NWW-1:0] nrd_q;
	logic [NW:0]         prd_q;
	logic [NW-1:0]       nrd_addr;

	// Leaf weight overlay: a leaf that was never written reads the default table,
	// and a leaf cleared by a build reads zero.
	logic [MAX_SYMBOLS-1:0] written_q;
	logic [MAX_SYMBOLS-1:0] zero_q;
	logic [MAX_SYMBOLS-1:0] beyond_n;
	logic [NODES-1:0]       parented_q;

	logic [5:0]    symbol_count_q;
	logic [CW-1:0] bld_n_q;
	logic [CW-1:0] built_q;
	logic [NW-1:0] root_q;
	logic [NW-1:0] cursor_q;
	logic          tree_ready_q;
	logic          dec_bit_q;

	logic [NW-1:0]  i_q, j_q, j_s1, a_q, b_q, t_q;
	logic           vld_s1, a_vld_q, b_vld_q;
	logic [NWW-1:0] wa_q, wb_q;

	logic [MAX_SYMBOLS-2:0] path_q;
	logic [LW-1:0]          len_q;

	logic      res_vld_q;
	out_item_t res_q;
	logic      res_vld_nxt;
	out_item_t res_nxt;

	logic [CW-1:0]  n_clamp;
	logic [NW-1:0]  n_root;
	logic [NWW-1:0] wv;
	logic [NW-1:0]  dec_next;
	logic           scan_issue;
	logic           accept;
	logic           cfg_wr;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {26'd0, symbol_count_q};
	assign result_valid = res_vld_q;
	assign result       = res_q;

	// Clamp the programmed count into the supported range.
	always_comb begin
		if (symbol_count_q < 6'd2) begin
			n_clamp = CW'(2);
		end else if (7'(symbol_count_q) > 7'(MAX_SYMBOLS)) begin
			n_clamp = CW'(MAX_SYMBOLS);
		end else begin
			n_clamp = CW'(symbol_count_q);
		end
	end

	// Leaves at or beyond the build count.
	always_comb begin
		for (int k = 0; k < MAX_SYMBOLS; k++) begin
			beyond_n[k] = (CW'(k) >= bld_n_q);
		end
	end

	assign n_root     = NW'({bld_n_q, 1'b0}) - NW'(2);
	assign scan_issue = (state_q == S_SCAN) && (j_q < i_q);
	assign nrd_addr   = (state_q == S_SCAN) ? j_q : cursor_q;
	assign dec_next   = dec_bit_q ? nrd_q[NWW+NW-1:NWW] : nrd_q[NWW+2*NW-1:NWW+NW];

	// Weight seen by the scan compare, with the leaf overlay applied.
	always_comb begin
		wv = nrd_q[NWW-1:0];
		if (j_s1 < NW'(MAX_SYMBOLS)) begin
			if (zero_q[j_s1[LW-1:0]]) begin
				wv = '0;
			end else if (!written_q[j_s1[LW-1:0]]) begin
				wv = NWW'(dflt_weight(7'(j_s1))) & WMASK;
			end
		end
	end

	// Result beat for the next cycle.
	always_comb begin
		res_nxt     = '0;
		res_vld_nxt = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept && in_item.action != ACT_LOAD && in_item.action != ACT_BUILD) begin
					if (!tree_ready_q) begin
						res_nxt.kind       = KIND_ERROR;
						res_nxt.error_code = ERR_NO_TREE;
						res_vld_nxt        = 1'b1;
					end else if (in_item.action == ACT_ENCODE &&
						7'(in_item.symbol) >= 7'(built_q)) begin
						res_nxt.kind       = KIND_ERROR;
						res_nxt.error_code = ERR_RANGE;
						res_vld_nxt        = 1'b1;
					end
				end
			end
			S_MRGB: begin
				res_nxt.kind = KIND_BUILD;
				res_vld_nxt  = (i_q == n_root);
			end
			S_EEMIT: begin
				res_nxt.kind    = KIND_CODE;
				res_nxt.out_bit = path_q[0];
				res_nxt.last    = (len_q == LW'(1));
				res_vld_nxt     = 1'b1;
			end
			S_DWAIT: begin
				res_nxt.kind       = KIND_SYMBOL;
				res_nxt.out_symbol = 5'(dec_next);
				res_vld_nxt        = (NW'(built_q) > dec_next);
			end
			default: begin
			end
		endcase
	end

	// Node memory: loads write a leaf weight only, each merge writes a whole entry.
	// A merge writes node i before any scan can address it, so reads never race writes.
	always_ff @(posedge clk) begin
		if (accept && in_item.action == ACT_LOAD && 7'(in_item.symbol) < 7'(MAX_SYMBOLS)) begin
			nmem[NW'(in_item.symbol)][NWW-1:0] <= NWW'(in_item.weight) & WMASK;
		end else if (state_q == S_MRGA) begin
			nmem[i_q] <= {a_q, b_q, wa_q + wb_q};
		end
		nrd_q <= nmem[nrd_addr];
	end

	// Parent memory: both children of a merge are linked, the first in S_MRGA, the second in S_MRGB.
	always_ff @(posedge clk) begin
		if (state_q == S_MRGA) begin
			pmem[a_q] <= {1'b0, i_q};
		end else if (state_q == S_MRGB) begin
			pmem[b_q] <= {1'b1, i_q};
		end
		prd_q <= pmem[t_q];
	end

	// Payload registers of the scan and the encode path need no reset.
	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		dec_bit_q <= (accept) ? in_item.code_bit : dec_bit_q;
		if (state_q == S_SCAN && vld_s1 && !parented_q[j_s1]) begin
			if (!a_vld_q || wv < wa_q) begin
				a_q  <= j_s1;
				wa_q <= wv;
				b_q  <= a_q;
				wb_q <= wa_q;
			end else if (!b_vld_q || wv < wb_q) begin
				b_q  <= j_s1;
				wb_q <= wv;
			end
		end
		if (state_q == S_EWAIT) begin
			path_q <= {path_q[MAX_SYMBOLS-3:0], prd_q[NW]};
		end else if (state_q == S_EEMIT) begin
			path_q <= path_q >> 1;
		end
		res_q <= res_nxt;
	end

	// Control: sequencer, counters, flags and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			symbol_count_q <= 6'(RESET_COUNT);
			bld_n_q        <= CW'(RST_N);
			built_q        <= CW'(RST_N);
			root_q         <= NW'(2 * RST_N - 2);
			cursor_q       <= NW'(2 * RST_N - 2);
			tree_ready_q   <= 1'b0;
			written_q      <= '0;
			zero_q         <= '0;
			parented_q     <= '0;
			i_q            <= '0;
			j_q            <= '0;
			t_q            <= '0;
			len_q          <= '0;
			vld_s1         <= 1'b0;
			a_vld_q        <= 1'b0;
			b_vld_q        <= 1'b0;
			res_vld_q      <= 1'b0;
		end else begin
			res_vld_q <= res_vld_nxt;
			vld_s1    <= scan_issue;
			if (cfg_wr) begin
				symbol_count_q <= pwdata[5:0];
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_item.action)
							ACT_LOAD: begin
								if (7'(in_item.symbol) < 7'(MAX_SYMBOLS)) begin
									written_q[LW'(in_item.symbol)] <= 1'b1;
									zero_q[LW'(in_item.symbol)]    <= 1'b0;
								end
							end
							ACT_BUILD: begin
								bld_n_q <= n_clamp;
								state_q <= S_BINIT;
							end
							ACT_ENCODE: begin
								if (tree_ready_q && 7'(in_item.symbol) < 7'(built_q)) begin
									t_q     <= NW'(in_item.symbol);
									len_q   <= '0;
									state_q <= S_EREQ;
								end
							end
							ACT_DECODE: begin
								if (tree_ready_q) begin
									state_q <= S_DREQ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_BINIT: begin
					// Every node loses its parent; leaves at or beyond the count read zero.
					parented_q <= '0;
					zero_q     <= zero_q | beyond_n;
					i_q        <= NW'(bld_n_q);
					j_q        <= '0;
					a_vld_q    <= 1'b0;
					b_vld_q    <= 1'b0;
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_issue) begin
						j_q <= j_q + NW'(1);
					end
					if (vld_s1 && !parented_q[j_s1]) begin
						if (!a_vld_q || wv < wa_q) begin
							a_vld_q <= 1'b1;
							b_vld_q <= a_vld_q;
						end else if (!b_vld_q || wv < wb_q) begin
							b_vld_q <= 1'b1;
						end
					end
					if (!scan_issue && !vld_s1) begin
						state_q <= S_MRGA;
					end
				end
				S_MRGA: begin
					parented_q <= parented_q | (NODES'(1) << a_q) | (NODES'(1) << b_q);
					if (i_q < NW'(MAX_SYMBOLS)) begin
						written_q[i_q[LW-1:0]] <= 1'b1;
						zero_q[i_q[LW-1:0]]    <= 1'b0;
					end
					state_q <= S_MRGB;
				end
				S_MRGB: begin
					if (i_q == n_root) begin
						built_q      <= bld_n_q;
						root_q       <= n_root;
						cursor_q     <= n_root;
						tree_ready_q <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						i_q     <= i_q + NW'(1);
						j_q     <= '0;
						a_vld_q <= 1'b0;
						b_vld_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_EREQ: begin
					// The parent read of t_q is in flight; stop once the root is reached.
					state_q <= (t_q == root_q) ? S_EEMIT : S_EWAIT;
				end
				S_EWAIT: begin
					t_q     <= prd_q[NW-1:0];
					len_q   <= len_q + LW'(1);
					state_q <= S_EREQ;
				end
				S_EEMIT: begin
					len_q <= len_q - LW'(1);
					if (len_q == LW'(1)) begin
						state_q <= S_IDLE;
					end
				end
				S_DREQ: begin
					state_q <= S_DWAIT;
				end
				S_DWAIT: begin
					cursor_q <= (NW'(built_q) > dec_next) ? root_q : dec_next;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`HTC_ASSERT_NOW(a_res_cause, result_valid, $past(busy) || $past(start), "beat without cause")
	`HTC_ASSERT_NOW(a_merge_pair, state_q == S_MRGA, a_vld_q && b_vld_q && a_q != b_q, "bad merge")
	`HTC_ASSERT_NOW(a_emit_len, state_q == S_EEMIT, len_q != '0, "code emission with empty path")
	`HTC_ASSERT_NEXT(a_build_ready, state_q == S_MRGB && i_q == n_root, tree_ready_q && result_valid, "no done beat")

endmodule
